### sv/sida_pkg.sv
// ----------------------------------------------------------------------------
// sida_pkg
// Shared widths, character codes and the hand-off type between the
// binary-to-BCD converter and the character emitter.
// ----------------------------------------------------------------------------
package sida_pkg;

  localparam int VALUE_W    = 32;
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = 10;
  localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
  localparam int CHAR_W     = 8;
  localparam int BITCNT_W   = $clog2(VALUE_W);
  localparam int REMAIN_W   = $clog2(NUM_DIGITS + 1);

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

  // Converted number, valid for one cycle when the conversion ends
  typedef struct packed {
    logic             valid;
    logic             neg;
    logic [BCD_W-1:0] bcd;
  } sida_num_t;

endpackage

### sv/sida_dabble.sv
// ----------------------------------------------------------------------------
// sida_dabble
// Bit-serial binary to BCD converter (shift and add-3). Takes the magnitude
// of a signed value and shifts one bit per cycle into ten BCD digits.
// ----------------------------------------------------------------------------
module sida_dabble (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [sida_pkg::VALUE_W-1:0]     value,
  output sida_pkg::sida_num_t              num
);
  import sida_pkg::*;

  logic                running;
  logic                done;
  logic                neg;
  logic [VALUE_W-1:0]  bin;
  logic [BCD_W-1:0]    bcd;
  logic [BCD_W-1:0]    bcd_adj;
  logic [BITCNT_W-1:0] count;

  // Add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (bcd[d*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
        bcd_adj[d*DIGIT_W +: DIGIT_W] = bcd[d*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
      end else begin
        bcd_adj[d*DIGIT_W +: DIGIT_W] = bcd[d*DIGIT_W +: DIGIT_W];
      end
    end
  end

  // Control: one pass of VALUE_W shift steps
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= running && !start && (count == BITCNT_W'(VALUE_W - 1));
      if (start) begin
        running <= 1'b1;
        count   <= '0;
      end else if (running) begin
        count <= count + BITCNT_W'(1);
        if (count == BITCNT_W'(VALUE_W - 1)) begin
          running <= 1'b0;
        end
      end
    end
  end

  // Datapath: load magnitude, then shift one bit into the BCD digits
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= value[VALUE_W-1];
      bin <= value[VALUE_W-1] ? (VALUE_W'(0) - value) : value;
      bcd <= '0;
    end else if (running) begin
      bcd <= {bcd_adj[BCD_W-2:0], bin[VALUE_W-1]};
      bin <= {bin[VALUE_W-2:0], 1'b0};
    end
  end

  assign num.valid = done;
  assign num.neg   = neg;
  assign num.bcd   = bcd;

endmodule

### sv/sida_emit.sv
// ----------------------------------------------------------------------------
// sida_emit
// Character emitter. Sends the sign, drops leading zero digits, then shifts
// out one BCD digit per transfer as ASCII through an output register.
// ----------------------------------------------------------------------------
module sida_emit (
  input  logic                          clk,
  input  logic                          rst,
  input  sida_pkg::sida_num_t           num,
  output logic                          busy,
  output logic                          char_valid,
  input  logic                          char_ready,
  output logic [sida_pkg::CHAR_W-1:0]   ascii_char,
  output logic                          is_last
);
  import sida_pkg::*;

  logic                sign_pend;
  logic                lead_zero;
  logic [BCD_W-1:0]    digits;
  logic [REMAIN_W-1:0] remain;
  logic                slot_free;
  logic [DIGIT_W-1:0]  top_digit;
  logic                skip;
  logic                send;

  assign slot_free = !char_valid || char_ready;
  assign top_digit = digits[BCD_W-1 -: DIGIT_W];

  // Drop a zero only while no digit has been sent; the last digit always goes
  assign skip = lead_zero && (top_digit == '0) && (remain > REMAIN_W'(1));
  assign send = busy && slot_free && (sign_pend || !skip);

  // Control: sign, zero skip, digit transfers
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      sign_pend  <= 1'b0;
      lead_zero  <= 1'b0;
      char_valid <= 1'b0;
      remain     <= '0;
    end else begin
      if (send) begin
        char_valid <= 1'b1;
      end else if (char_ready) begin
        char_valid <= 1'b0;
      end
      if (num.valid && !busy) begin
        busy      <= 1'b1;
        sign_pend <= num.neg;
        lead_zero <= 1'b1;
        remain    <= REMAIN_W'(NUM_DIGITS);
      end else if (busy && slot_free) begin
        if (sign_pend) begin
          sign_pend <= 1'b0;
        end else if (skip) begin
          remain <= remain - REMAIN_W'(1);
        end else begin
          lead_zero <= 1'b0;
          remain    <= remain - REMAIN_W'(1);
          if (remain == REMAIN_W'(1)) begin
            busy <= 1'b0;
          end
        end
      end
    end
  end

  // Datapath: digit shift register and output character
  always_ff @(posedge clk) begin
    if (num.valid && !busy) begin
      digits <= num.bcd;
    end else if (busy && slot_free) begin
      if (sign_pend) begin
        ascii_char <= ASCII_MINUS;
        is_last    <= 1'b0;
      end else begin
        digits <= {digits[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
        if (!skip) begin
          ascii_char <= ASCII_ZERO + CHAR_W'(top_digit);
          is_last    <= (remain == REMAIN_W'(1));
        end
      end
    end
  end

endmodule

### sv/signed_int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Prints a signed 32-bit integer as decimal ASCII, one character per transfer.
// ----------------------------------------------------------------------------
//  channel  handshake                  payload
//  input    value_valid / value_ready  value[31:0] (signed)
//  output   char_valid  / char_ready   ascii_char[7:0], is_last
//
//  A number is accepted, converted bit-serially in the BCD converter and
//  handed over to the emitter, which uses ten digit slots (a leading zero
//  dropped or a digit sent) plus one for a minus sign, and then returns to
//  idle. The input reopens in the cycle after the emitter goes idle. Output
//  stalls hold the emitter; rst clears all control state.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          value_valid,
  output logic                          value_ready,
  input  logic signed [sida_pkg::VALUE_W-1:0] value,
  output logic                          char_valid,
  input  logic                          char_ready,
  output logic [sida_pkg::CHAR_W-1:0]   ascii_char,
  output logic                          is_last
);
  import sida_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       start;
  logic       emit_busy;
  sida_num_t  conv_num;

  assign value_ready = (state == ST_IDLE);
  assign start       = value_valid && value_ready;

  // Sequence one number at a time
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (start) state_next = ST_CONV;
      ST_CONV: if (conv_num.valid) state_next = ST_EMIT;
      ST_EMIT: if (!emit_busy) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  sida_dabble u_dabble (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .value (value),
    .num   (conv_num)
  );

  sida_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .num        (conv_num),
    .busy       (emit_busy),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .ascii_char (ascii_char),
    .is_last    (is_last)
  );

`ifndef SYNTH
  // Emitter is free whenever a new number may be taken
  a_idle_emit_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !emit_busy)
    else $error("emitter busy while input is open");

  // Conversion result arrives only while converting
  a_done_in_conv: assert property (@(posedge clk) disable iff (rst)
    conv_num.valid |-> (state == ST_CONV))
    else $error("converter result outside conversion");

  // Every character is a minus sign or a decimal digit
  a_char_legal: assert property (@(posedge clk) disable iff (rst)
    char_valid |-> (ascii_char == ASCII_MINUS ||
                    (ascii_char >= ASCII_ZERO && ascii_char <= ASCII_NINE)))
    else $error("illegal output character");

  // A minus sign is never the final character
  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (char_valid && ascii_char == ASCII_MINUS) |-> !is_last)
    else $error("minus sign flagged as last");
`endif

endmodule
